[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the port checker ast_checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define AST_CHECK_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("port check failed");

// next-cycle implication
`define AST_CHECK_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("port check failed");

`endif

[rtl/core/ast_pkg.sv]
// ----------------------------------------------------------------------------
// ast_pkg
// Widths, register codes and the pipeline sideband type of the arrive
// steering accelerator.
// ----------------------------------------------------------------------------
package ast_pkg;

   localparam int COORD_W  = 24;
   localparam int ACC_W    = COORD_W - 1;
   localparam int OFS_W    = COORD_W + 1;
   localparam int DIST_W   = 2 * OFS_W;
   localparam int RAD_W    = 47;
   localparam int FRAC_Q   = 16;
   localparam int Q_W      = FRAC_Q + 1;
   localparam int RAW_W    = COORD_W + 5;
   localparam int RMAG_W   = RAW_W - 1;
   localparam int RSQ_W    = 2 * RMAG_W + 1;

   localparam int SQ_IN_W  = (DIST_W > RSQ_W) ? DIST_W : RSQ_W;
   localparam int ROOT_W   = (SQ_IN_W + 1) / 2;
   localparam int SQ_T_W   = 2 * ROOT_W + 1;

   localparam int NUM_A_W  = RAD_W + FRAC_Q;
   localparam int NUM_B_W  = RMAG_W + ACC_W;
   localparam int NUM_C_W  = OFS_W + ACC_W;
   localparam int NUM_AB_W = (NUM_A_W > NUM_B_W) ? NUM_A_W : NUM_B_W;
   localparam int NUM_W    = (NUM_AB_W > NUM_C_W) ? NUM_AB_W : NUM_C_W;
   localparam int DEN_W    = (RAD_W > ROOT_W) ? RAD_W : ROOT_W;
   localparam int QUO_W    = (COORD_W > Q_W) ? COORD_W : Q_W;
   localparam int CMP_W    = DEN_W + QUO_W;

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_ARRIVED = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_SLOW    = CSR_IDX_W'(1);

   localparam logic [RAD_W-1:0] ARRIVED_RESET = RAD_W'(65536);
   localparam logic [RAD_W-1:0] SLOW_RESET    = RAD_W'(6553600);

   typedef struct packed {
      logic                       arrived;
      logic                       far;
      logic                       slow_zero;
      logic                       clamp;
      logic                       dx_neg;
      logic                       dy_neg;
      logic [OFS_W-1:0]           ax;
      logic [OFS_W-1:0]           ay;
      logic [DIST_W-1:0]          dsq;
      logic signed [COORD_W-1:0]  vx;
      logic signed [COORD_W-1:0]  vy;
      logic [ACC_W-1:0]           m;
      logic [ACC_W-1:0]           speed;
      logic signed [RAW_W-1:0]    rx;
      logic signed [RAW_W-1:0]    ry;
   } side_type;

endpackage

[rtl/core/arrive_steering_accel.sv]
// Throughput: one word per cycle; a stalled rsp word holds the whole pipeline.
// The bit-per-stage units lie in series: ratio divider,
// direction root and divider, clamp root and divider (24 or 29 stages each).
// Reset clears all valid bits and loads the radius registers with defaults.
// ----------------------------------------------------------------------------
// arrive_steering_accel
// Arrive steering acceleration pipeline with radius configuration registers.
// ----------------------------------------------------------------------------
module arrive_steering_accel
   import ast_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [COORD_W-1:0]  req_target_x,
   input  logic signed [COORD_W-1:0]  req_target_y,
   input  logic signed [COORD_W-1:0]  req_pos_x,
   input  logic signed [COORD_W-1:0]  req_pos_y,
   input  logic signed [COORD_W-1:0]  req_vel_x,
   input  logic signed [COORD_W-1:0]  req_vel_y,
   input  logic [ACC_W-1:0]           req_max_accel,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [COORD_W-1:0]  rsp_accel_x,
   output logic signed [COORD_W-1:0]  rsp_accel_y,
   output logic                       rsp_arrived,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [RAD_W-1:0]           csr_data
);

   logic adv;

   logic [RAD_W-1:0] arr_rad_ff, slow_rad_ff;

   logic       geo_valid, dq_valid, l1_valid, du_valid, l2_valid, dc_valid;
   side_type   geo_side, dq_side, l1_side, du_side, l2_side, dc_side;
   logic [QUO_W-1:0]  dq_quo, du_quo_a, du_quo_b, dc_quo_a, dc_quo_b;
   logic [ROOT_W-1:0] l1_root, l2_root;

   logic                     sp_valid_ff;
   side_type                 sp_side_ff, sp_side_in;
   logic [ACC_W+Q_W-1:0]     sp_prod;

   logic                     mu_valid_ff;
   logic [NUM_W-1:0]         mu_pa_ff, mu_pb_ff, mu_pa_in, mu_pb_in;
   logic [DEN_W-1:0]         mu_len_ff;
   side_type                 mu_side_ff;

   logic                     rw_valid_ff;
   side_type                 rw_side_ff, rw_side_in;
   logic signed [RAW_W-1:0]  ux_s, uy_s, sx, sy, dvx, dvy;

   logic                     sq_valid_ff;
   logic [RMAG_W-1:0]        rax, ray, rax2, ray2;
   logic [2*RMAG_W-1:0]      sq_a_ff, sq_b_ff, sq_a_in, sq_b_in;
   logic [2*ACC_W-1:0]       sq_m_ff, sq_m_in;
   side_type                 sq_side_ff;

   logic                     cm_valid_ff;
   logic [RSQ_W-1:0]         cm_sum_ff, cm_sum_in;
   side_type                 cm_side_ff, cm_side_in;

   logic                     mc_valid_ff;
   logic [NUM_W-1:0]         mc_pa_ff, mc_pb_ff, mc_pa_in, mc_pb_in;
   logic [DEN_W-1:0]         mc_len_ff;
   side_type                 mc_side_ff;

   logic                     rsp_valid_ff, rsp_arrived_ff;
   logic signed [COORD_W-1:0] rsp_x_ff, rsp_y_ff, rsp_x_in, rsp_y_in, cx_s, cy_s;

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;
   assign csr_ready = 1'b1;

   // radius registers
   always_ff @(posedge clock) begin
      if (reset) begin
         arr_rad_ff  <= ARRIVED_RESET;
         slow_rad_ff <= SLOW_RESET;
      end else if (csr_valid) begin
         if (csr_index == CSR_ARRIVED) begin
            arr_rad_ff <= csr_data;
         end else if (csr_index == CSR_SLOW) begin
            slow_rad_ff <= csr_data;
         end
      end
   end

   ast_geom u_geom (
      .clock        (clock),
      .reset        (reset),
      .en           (adv),
      .in_valid     (req_valid),
      .in_target_x  (req_target_x),
      .in_target_y  (req_target_y),
      .in_pos_x     (req_pos_x),
      .in_pos_y     (req_pos_y),
      .in_vel_x     (req_vel_x),
      .in_vel_y     (req_vel_y),
      .in_max_accel (req_max_accel),
      .arrived_rad  (arr_rad_ff),
      .slow_rad     (slow_rad_ff),
      .out_valid    (geo_valid),
      .out_side     (geo_side)
   );

   // slow-zone ratio dist * 2^16 / slow_radius_sq
   ast_div u_div_ratio (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (geo_valid),
      .in_num_a  (NUM_W'({geo_side.dsq, {FRAC_Q{1'b0}}})),
      .in_num_b  ('0),
      .in_den    (DEN_W'(slow_rad_ff)),
      .in_side   (geo_side),
      .out_valid (dq_valid),
      .out_quo_a (dq_quo),
      .out_quo_b (),
      .out_side  (dq_side)
   );

   always_comb begin
      sp_prod    = dq_side.m * dq_quo[Q_W-1:0];
      sp_side_in = dq_side;
      if (dq_side.far) begin
         sp_side_in.speed = dq_side.m;
      end else if (dq_side.slow_zero) begin
         sp_side_in.speed = '0;
      end else begin
         sp_side_in.speed = ACC_W'(sp_prod >> FRAC_Q);
      end
   end

   ast_sqrt u_sqrt_dir (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (sp_valid_ff),
      .in_rad    (SQ_IN_W'(sp_side_ff.dsq)),
      .in_side   (sp_side_ff),
      .out_valid (l1_valid),
      .out_root  (l1_root),
      .out_side  (l1_side)
   );

   always_comb begin
      mu_pa_in = l1_side.ax * l1_side.speed;
      mu_pb_in = l1_side.ay * l1_side.speed;
   end

   ast_div u_div_dir (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (mu_valid_ff),
      .in_num_a  (mu_pa_ff),
      .in_num_b  (mu_pb_ff),
      .in_den    (mu_len_ff),
      .in_side   (mu_side_ff),
      .out_valid (du_valid),
      .out_quo_a (du_quo_a),
      .out_quo_b (du_quo_b),
      .out_side  (du_side)
   );

   // desired minus velocity, times ten
   always_comb begin
      ux_s = RAW_W'(du_quo_a);
      uy_s = RAW_W'(du_quo_b);
      if (du_side.dsq == '0) begin
         sx = '0;
         sy = '0;
      end else begin
         sx = du_side.dx_neg ? -ux_s : ux_s;
         sy = du_side.dy_neg ? -uy_s : uy_s;
      end
      dvx = sx - RAW_W'(du_side.vx);
      dvy = sy - RAW_W'(du_side.vy);
      rw_side_in    = du_side;
      rw_side_in.rx = (dvx <<< 3) + (dvx <<< 1);
      rw_side_in.ry = (dvy <<< 3) + (dvy <<< 1);
   end

   always_comb begin
      rax     = RMAG_W'(rw_side_ff.rx[RAW_W-1] ? -rw_side_ff.rx : rw_side_ff.rx);
      ray     = RMAG_W'(rw_side_ff.ry[RAW_W-1] ? -rw_side_ff.ry : rw_side_ff.ry);
      sq_a_in = rax * rax;
      sq_b_in = ray * ray;
      sq_m_in = rw_side_ff.m * rw_side_ff.m;
   end

   always_comb begin
      cm_sum_in        = RSQ_W'(sq_a_ff) + RSQ_W'(sq_b_ff);
      cm_side_in       = sq_side_ff;
      cm_side_in.clamp = cm_sum_in > RSQ_W'(sq_m_ff);
   end

   ast_sqrt u_sqrt_clamp (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (cm_valid_ff),
      .in_rad    (SQ_IN_W'(cm_sum_ff)),
      .in_side   (cm_side_ff),
      .out_valid (l2_valid),
      .out_root  (l2_root),
      .out_side  (l2_side)
   );

   always_comb begin
      rax2     = RMAG_W'(l2_side.rx[RAW_W-1] ? -l2_side.rx : l2_side.rx);
      ray2     = RMAG_W'(l2_side.ry[RAW_W-1] ? -l2_side.ry : l2_side.ry);
      mc_pa_in = rax2 * l2_side.m;
      mc_pb_in = ray2 * l2_side.m;
   end

   ast_div u_div_clamp (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (mc_valid_ff),
      .in_num_a  (mc_pa_ff),
      .in_num_b  (mc_pb_ff),
      .in_den    (mc_len_ff),
      .in_side   (mc_side_ff),
      .out_valid (dc_valid),
      .out_quo_a (dc_quo_a),
      .out_quo_b (dc_quo_b),
      .out_side  (dc_side)
   );

   always_comb begin
      cx_s = dc_quo_a[COORD_W-1:0];
      cy_s = dc_quo_b[COORD_W-1:0];
      if (dc_side.arrived) begin
         rsp_x_in = '0;
         rsp_y_in = '0;
      end else if (dc_side.clamp) begin
         rsp_x_in = dc_side.rx[RAW_W-1] ? -cx_s : cx_s;
         rsp_y_in = dc_side.ry[RAW_W-1] ? -cy_s : cy_s;
      end else begin
         rsp_x_in = dc_side.rx[COORD_W-1:0];
         rsp_y_in = dc_side.ry[COORD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_valid_ff  <= 1'b0;
         mu_valid_ff  <= 1'b0;
         rw_valid_ff  <= 1'b0;
         sq_valid_ff  <= 1'b0;
         cm_valid_ff  <= 1'b0;
         mc_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         sp_valid_ff  <= dq_valid;
         mu_valid_ff  <= l1_valid;
         rw_valid_ff  <= du_valid;
         sq_valid_ff  <= rw_valid_ff;
         cm_valid_ff  <= sq_valid_ff;
         mc_valid_ff  <= l2_valid;
         rsp_valid_ff <= dc_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sp_side_ff     <= sp_side_in;
         mu_pa_ff       <= mu_pa_in;
         mu_pb_ff       <= mu_pb_in;
         mu_len_ff      <= DEN_W'(l1_root);
         mu_side_ff     <= l1_side;
         rw_side_ff     <= rw_side_in;
         sq_a_ff        <= sq_a_in;
         sq_b_ff        <= sq_b_in;
         sq_m_ff        <= sq_m_in;
         sq_side_ff     <= rw_side_ff;
         cm_sum_ff      <= cm_sum_in;
         cm_side_ff     <= cm_side_in;
         mc_pa_ff       <= mc_pa_in;
         mc_pb_ff       <= mc_pb_in;
         mc_len_ff      <= DEN_W'(l2_root);
         mc_side_ff     <= l2_side;
         rsp_x_ff       <= rsp_x_in;
         rsp_y_ff       <= rsp_y_in;
         rsp_arrived_ff <= dc_side.arrived;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_accel_x = rsp_x_ff;
   assign rsp_accel_y = rsp_y_ff;
   assign rsp_arrived = rsp_arrived_ff;

endmodule

[rtl/core/ast_geom.sv]
// ----------------------------------------------------------------------------
// ast_geom
// Offset, squared distance and zone decode, three stages.
// ----------------------------------------------------------------------------
module ast_geom
   import ast_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       in_valid,
   input  logic signed [COORD_W-1:0]  in_target_x,
   input  logic signed [COORD_W-1:0]  in_target_y,
   input  logic signed [COORD_W-1:0]  in_pos_x,
   input  logic signed [COORD_W-1:0]  in_pos_y,
   input  logic signed [COORD_W-1:0]  in_vel_x,
   input  logic signed [COORD_W-1:0]  in_vel_y,
   input  logic [ACC_W-1:0]           in_max_accel,
   input  logic [RAD_W-1:0]           arrived_rad,
   input  logic [RAD_W-1:0]           slow_rad,
   output logic                       out_valid,
   output side_type                   out_side
);

   logic                       v1_ff, v2_ff, v3_ff;
   logic signed [OFS_W-1:0]    dx_ff, dy_ff, dx_in, dy_in;
   logic signed [COORD_W-1:0]  vx1_ff, vy1_ff, vx2_ff, vy2_ff;
   logic [ACC_W-1:0]           m1_ff, m2_ff;
   logic [OFS_W-1:0]           ax_in, ay_in, ax_ff, ay_ff;
   logic                       nx_ff, ny_ff;
   logic [DIST_W-1:0]          sqx_in, sqy_in, sqx_ff, sqy_ff, dist_in;
   side_type                   side_in, side_ff;

   always_comb begin
      dx_in  = OFS_W'(in_target_x) - OFS_W'(in_pos_x);
      dy_in  = OFS_W'(in_target_y) - OFS_W'(in_pos_y);
      ax_in  = dx_ff[OFS_W-1] ? OFS_W'(-dx_ff) : OFS_W'(dx_ff);
      ay_in  = dy_ff[OFS_W-1] ? OFS_W'(-dy_ff) : OFS_W'(dy_ff);
      sqx_in = ax_in * ax_in;
      sqy_in = ay_in * ay_in;
      dist_in = sqx_ff + sqy_ff;
   end

   always_comb begin
      side_in           = '0;
      side_in.dsq       = dist_in;
      side_in.arrived   = dist_in < DIST_W'(arrived_rad);
      side_in.far       = dist_in > DIST_W'(slow_rad);
      side_in.slow_zero = slow_rad == '0;
      side_in.dx_neg    = nx_ff;
      side_in.dy_neg    = ny_ff;
      side_in.ax        = ax_ff;
      side_in.ay        = ay_ff;
      side_in.vx        = vx2_ff;
      side_in.vy        = vy2_ff;
      side_in.m         = m2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dx_ff   <= dx_in;
         dy_ff   <= dy_in;
         vx1_ff  <= in_vel_x;
         vy1_ff  <= in_vel_y;
         m1_ff   <= in_max_accel;
         ax_ff   <= ax_in;
         ay_ff   <= ay_in;
         nx_ff   <= dx_ff[OFS_W-1];
         ny_ff   <= dy_ff[OFS_W-1];
         sqx_ff  <= sqx_in;
         sqy_ff  <= sqy_in;
         vx2_ff  <= vx1_ff;
         vy2_ff  <= vy1_ff;
         m2_ff   <= m1_ff;
         side_ff <= side_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_side  = side_ff;

endmodule

[rtl/core/ast_div.sv]
// ----------------------------------------------------------------------------
// ast_div
// Two-lane pipelined restoring divider, one quotient bit per stage,
// shared divisor, sideband carried alongside.
// ----------------------------------------------------------------------------
module ast_div
   import ast_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [NUM_W-1:0]  in_num_a,
   input  logic [NUM_W-1:0]  in_num_b,
   input  logic [DEN_W-1:0]  in_den,
   input  side_type          in_side,
   output logic              out_valid,
   output logic [QUO_W-1:0]  out_quo_a,
   output logic [QUO_W-1:0]  out_quo_b,
   output side_type          out_side
);

   logic              stg_valid [QUO_W+1];
   logic [NUM_W-1:0]  stg_rem_a [QUO_W+1];
   logic [NUM_W-1:0]  stg_rem_b [QUO_W+1];
   logic [QUO_W-1:0]  stg_quo_a [QUO_W+1];
   logic [QUO_W-1:0]  stg_quo_b [QUO_W+1];
   logic [DEN_W-1:0]  stg_den   [QUO_W+1];
   side_type          stg_side  [QUO_W+1];

   assign stg_valid[0] = in_valid;
   assign stg_rem_a[0] = in_num_a;
   assign stg_rem_b[0] = in_num_b;
   assign stg_quo_a[0] = '0;
   assign stg_quo_b[0] = '0;
   assign stg_den[0]   = in_den;
   assign stg_side[0]  = in_side;

   for (genvar j = 0; j < QUO_W; j++) begin : g_step
      localparam int K = QUO_W - 1 - j;

      logic [CMP_W-1:0]  shift_den, ext_a, ext_b;
      logic              ge_a, ge_b;
      logic [NUM_W-1:0]  rem_a_in, rem_b_in, rem_a_ff, rem_b_ff;
      logic [QUO_W-1:0]  quo_a_in, quo_b_in, quo_a_ff, quo_b_ff;
      logic [DEN_W-1:0]  den_ff;
      side_type          side_ff;
      logic              valid_ff;

      always_comb begin
         shift_den = CMP_W'(stg_den[j]) << K;
         ext_a     = CMP_W'(stg_rem_a[j]);
         ext_b     = CMP_W'(stg_rem_b[j]);
         ge_a      = ext_a >= shift_den;
         ge_b      = ext_b >= shift_den;
         rem_a_in  = ge_a ? NUM_W'(ext_a - shift_den) : stg_rem_a[j];
         rem_b_in  = ge_b ? NUM_W'(ext_b - shift_den) : stg_rem_b[j];
         quo_a_in    = stg_quo_a[j];
         quo_a_in[K] = ge_a;
         quo_b_in    = stg_quo_b[j];
         quo_b_in[K] = ge_b;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff <= 1'b0;
         end else if (en) begin
            valid_ff <= stg_valid[j];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_a_ff <= rem_a_in;
            rem_b_ff <= rem_b_in;
            quo_a_ff <= quo_a_in;
            quo_b_ff <= quo_b_in;
            den_ff   <= stg_den[j];
            side_ff  <= stg_side[j];
         end
      end

      assign stg_valid[j+1] = valid_ff;
      assign stg_rem_a[j+1] = rem_a_ff;
      assign stg_rem_b[j+1] = rem_b_ff;
      assign stg_quo_a[j+1] = quo_a_ff;
      assign stg_quo_b[j+1] = quo_b_ff;
      assign stg_den[j+1]   = den_ff;
      assign stg_side[j+1]  = side_ff;
   end

   assign out_valid = stg_valid[QUO_W];
   assign out_quo_a = stg_quo_a[QUO_W];
   assign out_quo_b = stg_quo_b[QUO_W];
   assign out_side  = stg_side[QUO_W];

endmodule

[rtl/core/ast_sqrt.sv]
// ----------------------------------------------------------------------------
// ast_sqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module ast_sqrt
   import ast_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  logic [SQ_IN_W-1:0]  in_rad,
   input  side_type            in_side,
   output logic                out_valid,
   output logic [ROOT_W-1:0]   out_root,
   output side_type            out_side
);

   logic                stg_valid [ROOT_W+1];
   logic [SQ_IN_W-1:0]  stg_rem   [ROOT_W+1];
   logic [ROOT_W-1:0]   stg_root  [ROOT_W+1];
   side_type            stg_side  [ROOT_W+1];

   assign stg_valid[0] = in_valid;
   assign stg_rem[0]   = in_rad;
   assign stg_root[0]  = '0;
   assign stg_side[0]  = in_side;

   for (genvar j = 0; j < ROOT_W; j++) begin : g_step
      localparam int K = ROOT_W - 1 - j;

      logic [SQ_T_W-1:0]   trial, ext_rem;
      logic                ge;
      logic [SQ_IN_W-1:0]  rem_in, rem_ff;
      logic [ROOT_W-1:0]   root_in, root_ff;
      side_type            side_ff;
      logic                valid_ff;

      always_comb begin
         trial      = (SQ_T_W'(stg_root[j]) << (K + 1)) + (SQ_T_W'(1) << (2 * K));
         ext_rem    = SQ_T_W'(stg_rem[j]);
         ge         = ext_rem >= trial;
         rem_in     = ge ? SQ_IN_W'(ext_rem - trial) : stg_rem[j];
         root_in    = stg_root[j];
         root_in[K] = ge;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff <= 1'b0;
         end else if (en) begin
            valid_ff <= stg_valid[j];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff  <= rem_in;
            root_ff <= root_in;
            side_ff <= stg_side[j];
         end
      end

      assign stg_valid[j+1] = valid_ff;
      assign stg_rem[j+1]   = rem_ff;
      assign stg_root[j+1]  = root_ff;
      assign stg_side[j+1]  = side_ff;
   end

   assign out_valid = stg_valid[ROOT_W];
   assign out_root  = stg_root[ROOT_W];
   assign out_side  = stg_side[ROOT_W];

endmodule

[rtl/core/ast_checker.sv]
// ----------------------------------------------------------------------------
// ast_checker
// Port-level checks on the arrive steering accelerator, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ast_checker
   import ast_pkg::*;
(
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic signed [COORD_W-1:0]  rsp_accel_x,
   input logic signed [COORD_W-1:0]  rsp_accel_y,
   input logic                       rsp_arrived
);

   `AST_CHECK_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_accel_x) && $stable(rsp_accel_y) && $stable(rsp_arrived))
   `AST_CHECK_NOW(a_arrived_zero, clock, reset, rsp_valid && rsp_arrived,
      rsp_accel_x == '0 && rsp_accel_y == '0)
   `AST_CHECK_NOW(a_stall_back, clock, reset, rsp_valid && !rsp_ready, !req_ready)
   `AST_CHECK_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)
   `AST_CHECK_NOW(a_idle_ready, clock, reset, !rsp_valid && req_valid, req_ready)

endmodule

bind arrive_steering_accel ast_checker u_ast_checker (.*);
